// ===== rtl/gdr_pkg.sv =====
// Package: shared constants, types and the sine table of the grid DDA ray caster.
package gdr_pkg;

  localparam int MAP_SIDE         = 64;
  localparam int SCREEN_WIDTH     = 1024;
  localparam int SCREEN_HEIGHT    = 512;
  localparam int TRIG_TABLE_DEPTH = 1024;

  localparam int MAP_BITS  = $clog2(MAP_SIDE);
  localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
  localparam int MAP_AW    = $clog2(MAP_CELLS);
  // signed room for a walk coordinate one cell either side of the map
  localparam int CW        = ((MAP_BITS > 6) ? MAP_BITS : 6) + 2;
  localparam int MAX_STEPS = 4 * MAP_SIDE + 4;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam int TRIG_BITS = $clog2(TRIG_TABLE_DEPTH);
  localparam int QUARTER   = TRIG_TABLE_DEPTH / 4;
  localparam int QK_BITS   = TRIG_BITS - 2;

  // fixed-point widths
  localparam int LEN_W   = 51;   // ray lengths, room for the infinite marker
  localparam int DOT_W   = 35;   // signed dot product of two Q16 unit vectors
  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 42;
  localparam int DIV_D_W = 23;

  localparam logic [LEN_W-1:0]   LEN_INF  = LEN_W'(1) << 50;
  localparam logic [LEN_W-1:0]   LEN_CAP  = LEN_W'(1) << 40;
  localparam logic [22:0]        DIST_MAX = 23'h7FFFFF;
  localparam logic [DIV_N_W-1:0] RECIP_NUM = DIV_N_W'(1) << 32;
  localparam logic [DIV_N_W-1:0] H_NUM     = DIV_N_W'(SCREEN_HEIGHT) << 32;
  localparam logic [43:0]        H_FULL    = 44'(SCREEN_HEIGHT) << 16;

  typedef enum logic [0:0] {OP_WRITE = 1'b0, OP_CAST = 1'b1} op_t;

  typedef enum logic [1:0] {
    CFG_PLAYER_X   = 2'd0,
    CFG_PLAYER_Y   = 2'd1,
    CFG_VIEW_ANGLE = 2'd2,
    CFG_FOV_ANGLE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_EAST  = 2'd2,
    FACE_WEST  = 2'd3
  } face_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } trig_t;

  typedef logic [16:0] sin_tab_t [QUARTER];

  function automatic longint mul_q30(input longint a, input longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint          r;
    ua = (a < 0) ? longint'(-a) : longint'(a);
    ub = (b < 0) ? longint'(-b) : longint'(b);
    r  = longint'((ua * ub) >> 30);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // worked out at elaboration: quarter-wave sine in Q16
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint   x;
    longint   x2;
    longint   t;
    for (int k = 0; k < QUARTER; k++) begin
      x  = longint'(k) << (30 - QK_BITS);
      x2 = mul_q30(x, x);
      t  = 172273;
      t  = -5026991 + mul_q30(t, x2);
      t  = 85569306 + mul_q30(t, x2);
      t  = -693598668 + mul_q30(t, x2);
      t  = 1686629713 + mul_q30(t, x2);
      t  = mul_q30(t, x);
      if (t < 0) t = 0;
      if (t > 1073741824) t = 1073741824;
      t = (t + 8192) >>> 14;
      if (t > 65536) t = 65536;
      tab[k] = 17'(t);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic signed [17:0] sine_of_index(input logic [TRIG_BITS-1:0] idx);
    logic [1:0]         quad;
    logic [QK_BITS-1:0] k;
    logic [QK_BITS:0]   x;
    logic [16:0]        mag;
    quad = idx[TRIG_BITS-1 -: 2];
    k    = idx[QK_BITS-1:0];
    x    = quad[0] ? ((QK_BITS+1)'(QUARTER) - {1'b0, k}) : {1'b0, k};
    mag  = x[QK_BITS] ? 17'(65536) : SIN_TAB[x[QK_BITS-1:0]];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic trig_t trig_lookup(input logic [15:0] ang);
    trig_t                r;
    logic [TRIG_BITS-1:0] i;
    i   = ang[15 -: TRIG_BITS];
    r.s = sine_of_index(i);
    r.c = sine_of_index(i + TRIG_BITS'(QUARTER));
    return r;
  endfunction

  function automatic logic in_map(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return !x[CW-1] && !y[CW-1] && (x < CW'(MAP_SIDE)) && (y < CW'(MAP_SIDE));
  endfunction

endpackage

// ===== rtl/gdr_if.sv =====
// Interfaces: cast/write item channel and result item channel.
interface gdr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic       is_wall;
  logic [9:0] column;

  modport source (output valid, op, cell_x, cell_y, is_wall, column, input ready);
  modport sink   (input valid, op, cell_x, cell_y, is_wall, column, output ready);
endinterface

interface gdr_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  column_out;
  logic [8:0]  span_first;
  logic [8:0]  span_last;
  logic        face_axis;
  logic [1:0]  hit_face;
  logic [5:0]  hit_cell_x;
  logic [5:0]  hit_cell_y;
  logic [22:0] distance;
  logic        escaped;

  modport source (output valid, column_out, span_first, span_last, face_axis, hit_face,
                  hit_cell_x, hit_cell_y, distance, escaped, input ready);
  modport sink   (input valid, column_out, span_first, span_last, face_axis, hit_face,
                  hit_cell_x, hit_cell_y, distance, escaped, output ready);
endinterface

// ===== rtl/gdr_mul_seq.sv =====
// Shift-add multiplier, one bit of the short operand per cycle.
module gdr_mul_seq
  import gdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MUL_P_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_P_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= MUL_P_W'(req.a);
        b_r    <= req.b;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r   <= a_r << 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== rtl/gdr_div_seq.sv =====
// Restoring divider, one quotient bit per cycle.
module gdr_div_seq
  import gdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_N_W-1:0] q_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W:0]   sh;
  logic               fits;

  assign sh   = {rem_r, q_r[DIV_N_W-1]};
  assign fits = sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_D_W'(sh - {1'b0, d_r}) : sh[DIV_D_W-1:0];
        q_r   <= {q_r[DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== rtl/grid_dda_ray_caster_unit.sv =====
// Top level: wall map store, ray set-up sequencer and DDA grid walk.
//
// A write item stores one wall bit in the cycle that it is accepted. A cast item
// runs alone through the sequencer: two table lookups, the dot product, two
// reciprocals on the shared divider and two start lengths on the shared
// multiplier (a zero direction component skips its reciprocal and start
// length), then the walk (per cell a step, then the registered map read),
// then the distance product and the wall-height division. A ray crosses at
// most 127 cells of the 64-cell-wide map. The result waits in an output
// register, and the next item is taken while it waits. After reset the map is
// cleared one cell a cycle, all 4096 cells, before the first item is taken;
// configuration writes go in at any time and must only be made while no cast
// is in flight.
module grid_dda_ray_caster_unit
  import gdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  gdr_in_if.sink            in_ch,
  gdr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [21:0]       cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TRIG, S_DOT1, S_DOT2,
    S_DIVX_GO, S_DIVX_W, S_MULX_GO, S_MULX_W,
    S_DIVY_GO, S_DIVY_W, S_MULY_GO, S_MULY_W,
    S_WALK0, S_STEP, S_CHECK,
    S_DIST_GO, S_DIST_W, S_DIVH_GO, S_DIVH_W, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [21:0] player_x_r;
  logic [21:0] player_y_r;
  logic [15:0] view_r;
  logic [14:0] fov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= 22'd163840;
      player_y_r <= 22'd163840;
      view_r     <= 16'd0;
      fov_r      <= 15'd10923;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PLAYER_X:   player_x_r <= cfg_wdata;
        CFG_PLAYER_Y:   player_y_r <= cfg_wdata;
        CFG_VIEW_ANGLE: view_r     <= cfg_wdata[15:0];
        CFG_FOV_ANGLE:  fov_r      <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // arithmetic units
  mul_req_t mul_req_r;
  mul_rsp_t mul_rsp;
  div_req_t div_req_r;
  div_rsp_t div_rsp;

  gdr_mul_seq u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req_r), .rsp(mul_rsp));
  gdr_div_seq u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .rsp(div_rsp));

  // ray working registers
  logic [9:0]         col_r;
  logic [15:0]        ray_r;
  logic signed [17:0] dx_r, dy_r, vx_r, vy_r;
  logic signed [DOT_W-1:0] dot_r;
  logic               sx_neg_r, sy_neg_r;
  logic [16:0]        adx_r, ady_r, frac_x_r, frac_y_r;
  logic [LEN_W-1:0]   del_x_r, del_y_r, len_x_r, len_y_r, t_r;
  logic [CW-1:0]      mx_r, my_r;
  logic [STEP_W-1:0]  step_r;
  logic [MAP_AW-1:0]  clr_addr_r;

  // result being built
  logic        res_side_r;
  logic [1:0]  res_face_r;
  logic [22:0] res_dist_r;
  logic [8:0]  res_start_r, res_end_r;
  logic        res_esc_r;

  // output register
  logic        out_valid_r;
  logic [9:0]  o_col_r;
  logic [8:0]  o_start_r, o_end_r;
  logic        o_side_r;
  logic [1:0]  o_face_r;
  logic [5:0]  o_cx_r, o_cy_r;
  logic [22:0] o_dist_r;
  logic        o_esc_r;

  // wall map
  logic              wall_mem [MAP_CELLS];
  logic              rd_bit_r;
  logic              mem_we;
  logic [MAP_AW-1:0] mem_wa;
  logic              mem_wd;
  logic [MAP_AW-1:0] rd_addr;

  logic in_acc;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  logic wr_in_map;
  assign wr_in_map = (int'(in_ch.cell_x) < MAP_SIDE) && (int'(in_ch.cell_y) < MAP_SIDE);

  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = 1'b0;
    end else begin
      mem_we = in_acc && (op_t'(in_ch.op) == OP_WRITE) && wr_in_map;
      mem_wa = MAP_AW'(in_ch.cell_y) * MAP_AW'(MAP_SIDE) + MAP_AW'(in_ch.cell_x);
      mem_wd = in_ch.is_wall;
    end
  end

  // one DDA step: pick the shorter axis
  logic          step_x;
  logic [CW-1:0] nx, ny;
  assign step_x = len_x_r < len_y_r;
  assign nx = step_x ? (mx_r + (sx_neg_r ? {CW{1'b1}} : CW'(1))) : mx_r;
  assign ny = step_x ? my_r : (my_r + (sy_neg_r ? {CW{1'b1}} : CW'(1)));
  assign rd_addr = MAP_AW'(ny) * MAP_AW'(MAP_SIDE) + MAP_AW'(nx);

  always_ff @(posedge clk) begin
    if (mem_we) wall_mem[mem_wa] <= mem_wd;
    rd_bit_r <= wall_mem[rd_addr];
  end

  // combinational helpers for the sequencer
  logic [24:0]       col_fov;
  trig_t             ray_trig, view_trig;
  logic [LEN_W-1:0]  t_cap;
  logic [MUL_B_W-1:0] dot_q;
  logic [42:0]       dist_full;
  logic [DIV_N_W-1:0] h_q;
  logic [43:0]       end_sum;
  logic              fin_load;

  assign col_fov   = 25'(in_ch.column) * 25'(fov_r);
  assign ray_trig  = trig_lookup(ray_r);
  assign view_trig = trig_lookup(view_r);
  assign t_cap     = (t_r > LEN_CAP) ? LEN_CAP : t_r;
  assign dot_q     = dot_r[DOT_W-1] ? '0 : dot_r[16 +: MUL_B_W];
  assign dist_full = mul_rsp.prod[MUL_P_W-1:16];
  assign h_q       = div_rsp.quot;
  assign end_sum   = H_FULL + 44'(h_q);
  // load the output register when the finished ray finds it free or draining
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_addr_r      <= '0;
      out_valid_r     <= 1'b0;
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      // start pulses last one cycle
      if (!(state_r inside {S_MULX_GO, S_MULY_GO, S_DIST_GO})) mul_req_r.start <= 1'b0;
      if (!(state_r inside {S_DIVX_GO, S_DIVY_GO, S_DIVH_GO})) div_req_r.start <= 1'b0;
      if (out_valid_r && out_ch.ready && !fin_load) out_valid_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + MAP_AW'(1);
          if (clr_addr_r == MAP_AW'(MAP_CELLS - 1)) state_r <= S_IDLE;
        end

        S_IDLE: begin
          if (in_acc && op_t'(in_ch.op) == OP_CAST) begin
            col_r   <= in_ch.column;
            ray_r   <= view_r - 16'(fov_r >> 1) + 16'(col_fov / SCREEN_WIDTH);
            state_r <= S_TRIG;
          end
        end

        S_TRIG: begin
          dx_r    <= ray_trig.c;
          dy_r    <= ray_trig.s;
          vx_r    <= view_trig.c;
          vy_r    <= view_trig.s;
          state_r <= S_DOT1;
        end

        S_DOT1: begin
          dot_r    <= DOT_W'(dx_r * vx_r);
          sx_neg_r <= dx_r[17];
          sy_neg_r <= dy_r[17];
          adx_r    <= 17'(dx_r[17] ? -dx_r : dx_r);
          ady_r    <= 17'(dy_r[17] ? -dy_r : dy_r);
          frac_x_r <= dx_r[17] ? {1'b0, player_x_r[15:0]}
                               : 17'(65536) - {1'b0, player_x_r[15:0]};
          frac_y_r <= dy_r[17] ? {1'b0, player_y_r[15:0]}
                               : 17'(65536) - {1'b0, player_y_r[15:0]};
          mx_r     <= CW'(player_x_r[21:16]);
          my_r     <= CW'(player_y_r[21:16]);
          step_r   <= '0;
          state_r  <= S_DOT2;
        end

        S_DOT2: begin
          dot_r   <= dot_r + DOT_W'(dy_r * vy_r);
          state_r <= S_DIVX_GO;
        end

        S_DIVX_GO: begin
          if (adx_r == '0) begin
            del_x_r <= LEN_INF;
            len_x_r <= LEN_INF;
            state_r <= S_DIVY_GO;
          end else begin
            div_req_r <= '{start: 1'b1, dividend: RECIP_NUM, divisor: DIV_D_W'(adx_r)};
            state_r   <= S_DIVX_W;
          end
        end

        S_DIVX_W: begin
          if (div_rsp.done) begin
            del_x_r <= LEN_W'(div_rsp.quot);
            state_r <= S_MULX_GO;
          end
        end

        S_MULX_GO: begin
          mul_req_r <= '{start: 1'b1, a: MUL_A_W'(del_x_r), b: MUL_B_W'(frac_x_r)};
          state_r   <= S_MULX_W;
        end

        S_MULX_W: begin
          if (mul_rsp.done) begin
            len_x_r <= LEN_W'(mul_rsp.prod[MUL_P_W-1:16]);
            state_r <= S_DIVY_GO;
          end
        end

        S_DIVY_GO: begin
          if (ady_r == '0) begin
            del_y_r <= LEN_INF;
            len_y_r <= LEN_INF;
            state_r <= S_WALK0;
          end else begin
            div_req_r <= '{start: 1'b1, dividend: RECIP_NUM, divisor: DIV_D_W'(ady_r)};
            state_r   <= S_DIVY_W;
          end
        end

        S_DIVY_W: begin
          if (div_rsp.done) begin
            del_y_r <= LEN_W'(div_rsp.quot);
            state_r <= S_MULY_GO;
          end
        end

        S_MULY_GO: begin
          mul_req_r <= '{start: 1'b1, a: MUL_A_W'(del_y_r), b: MUL_B_W'(frac_y_r)};
          state_r   <= S_MULY_W;
        end

        S_MULY_W: begin
          if (mul_rsp.done) begin
            len_y_r <= LEN_W'(mul_rsp.prod[MUL_P_W-1:16]);
            state_r <= S_WALK0;
          end
        end

        S_WALK0: begin
          // player outside the map: report an escaped ray
          if (in_map(mx_r, my_r)) begin
            state_r <= S_STEP;
          end else begin
            res_esc_r <= 1'b1;
            state_r   <= S_FIN;
          end
        end

        S_STEP: begin
          if (step_r == STEP_W'(MAX_STEPS)) begin
            res_esc_r <= 1'b1;
            state_r   <= S_FIN;
          end else begin
            step_r <= step_r + STEP_W'(1);
            mx_r   <= nx;
            my_r   <= ny;
            if (step_x) begin
              res_side_r <= 1'b0;
              res_face_r <= sx_neg_r ? FACE_WEST : FACE_EAST;
              t_r        <= len_x_r;
              len_x_r    <= len_x_r + del_x_r;
            end else begin
              res_side_r <= 1'b1;
              res_face_r <= sy_neg_r ? FACE_NORTH : FACE_SOUTH;
              t_r        <= len_y_r;
              len_y_r    <= len_y_r + del_y_r;
            end
            if (in_map(nx, ny)) begin
              state_r <= S_CHECK;
            end else begin
              res_esc_r <= 1'b1;
              state_r   <= S_FIN;
            end
          end
        end

        S_CHECK: begin
          state_r <= rd_bit_r ? S_DIST_GO : S_STEP;
        end

        S_DIST_GO: begin
          res_esc_r <= 1'b0;
          mul_req_r <= '{start: 1'b1, a: MUL_A_W'(t_cap), b: dot_q};
          state_r   <= S_DIST_W;
        end

        S_DIST_W: begin
          if (mul_rsp.done) begin
            res_dist_r <= (dist_full > 43'(DIST_MAX)) ? DIST_MAX : dist_full[22:0];
            if (dist_full == '0) begin
              // zero distance: span fills the column
              res_start_r <= 9'd0;
              res_end_r   <= 9'(SCREEN_HEIGHT - 1);
              state_r     <= S_FIN;
            end else begin
              state_r <= S_DIVH_GO;
            end
          end
        end

        S_DIVH_GO: begin
          div_req_r <= '{start: 1'b1, dividend: H_NUM, divisor: res_dist_r};
          state_r   <= S_DIVH_W;
        end

        S_DIVH_W: begin
          if (div_rsp.done) begin
            res_start_r <= (44'(h_q) >= H_FULL) ? 9'd0 : 9'((H_FULL - 44'(h_q)) >> 17);
            res_end_r   <= ((end_sum >> 17) > 44'(SCREEN_HEIGHT - 1))
                         ? 9'(SCREEN_HEIGHT - 1) : 9'(end_sum >> 17);
            state_r     <= S_FIN;
          end
        end

        S_FIN: begin
          // hold until the output register is free
          if (fin_load) begin
            out_valid_r <= 1'b1;
            o_col_r     <= col_r;
            o_esc_r     <= res_esc_r;
            if (res_esc_r) begin
              o_start_r <= 9'(SCREEN_HEIGHT / 2);
              o_end_r   <= 9'(SCREEN_HEIGHT / 2);
              o_side_r  <= 1'b0;
              o_face_r  <= 2'd0;
              o_cx_r    <= 6'd0;
              o_cy_r    <= 6'd0;
              o_dist_r  <= DIST_MAX;
            end else begin
              o_start_r <= res_start_r;
              o_end_r   <= res_end_r;
              o_side_r  <= res_side_r;
              o_face_r  <= res_face_r;
              o_cx_r    <= mx_r[5:0];
              o_cy_r    <= my_r[5:0];
              o_dist_r  <= res_dist_r;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.column_out = o_col_r;
  assign out_ch.span_first = o_start_r;
  assign out_ch.span_last  = o_end_r;
  assign out_ch.face_axis  = o_side_r;
  assign out_ch.hit_face   = o_face_r;
  assign out_ch.hit_cell_x = o_cx_r;
  assign out_ch.hit_cell_y = o_cy_r;
  assign out_ch.distance   = o_dist_r;
  assign out_ch.escaped    = o_esc_r;

  // a map check always follows the step that issued its read
  a_check_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> $past(state_r) == S_STEP)
    else $error("map check without a preceding step");

  // a new result appears only out of the finishing state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside the finishing state");

  // an accepted cast leaves the idle state at once
  a_cast_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.op |=> state_r == S_TRIG)
    else $error("cast item not started");

  // the shared units are never started together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req_r.start |-> !div_req_r.start && $past(state_r) != S_IDLE)
    else $error("multiplier and divider started together");

endmodule
